// File: rtl/atrlp_pkg.sv
`default_nettype none

package atrlp_pkg;

   // Default sizing of a line and of the payload copy.
   localparam int DEFAULT_LINE_MAX    = 64;
   localparam int DEFAULT_PAYLOAD_MAX = 64;

   // Field widths of the result word.
   localparam int ID_W     = 16;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int PLEN_W   = 6;

   // Characters the parser looks for.
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_O     = 8'h4F;
   localparam logic [7:0] CH_K     = 8'h4B;
   localparam logic [7:0] CH_R     = 8'h52;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_V     = 8'h56;
   localparam logic [7:0] CH_E     = 8'h45;
   localparam logic [7:0] CH_A     = 8'h41;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'd0,
      PH_PREFIX  = 4'd1,
      PH_SEEK_EQ = 4'd2,
      PH_ID      = 4'd3,
      PH_LEN     = 4'd4,
      PH_DATA    = 4'd5,
      PH_SIGN    = 4'd6,
      PH_RSSI    = 4'd7,
      PH_SNR     = 4'd8,
      PH_TAIL    = 4'd9
   } phase_type;

   // How much of the line prefix has matched so far.
   typedef enum logic [2:0] {
      PFX_NONE = 3'd0,
      PFX_PLUS = 3'd1,
      PFX_O    = 3'd2,
      PFX_R    = 3'd3,
      PFX_RC   = 3'd4,
      PFX_E    = 3'd5,
      PFX_ER   = 3'd6
   } prefix_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_RCV     = 3'd1,
      ST_ACK     = 3'd2,
      ST_MODERR  = 3'd3,
      ST_FMTERR  = 3'd4,
      ST_UNKNOWN = 3'd5
   } status_type;

   // One result word.
   typedef struct packed {
      logic                is_frame;
      logic [BYTE_W-1:0]   payload_byte;
      status_type          status;
      logic [ID_W-1:0]     sender_id;
      logic [BYTE_W-1:0]   declared_length;
      logic [PLEN_W-1:0]   payload_length;
      logic [BYTE_W-1:0]   rssi_magnitude;
      logic [BYTE_W-1:0]   snr_value;
   } rsp_word_type;

   // Input register contents handed to the parser.
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] rx_byte;
   } in_word_type;

   // Parser result handed to the output register.
   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } result_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

   // acc * 10 + digit, saturating at 16 bits.
   function automatic logic [15:0] sat_digit16(input logic [15:0] acc, input logic [3:0] d);
      logic [19:0] v;
      v = 20'(acc) * 20'd10 + 20'(d);
      return (v > 20'h0FFFF) ? 16'hFFFF : v[15:0];
   endfunction

   // acc * 10 + digit, saturating at 8 bits.
   function automatic logic [7:0] sat_digit8(input logic [7:0] acc, input logic [3:0] d);
      logic [11:0] v;
      v = 12'(acc) * 12'd10 + 12'(d);
      return (v > 12'h0FF) ? 8'hFF : v[7:0];
   endfunction

   function automatic logic [7:0] ack_char(input logic [1:0] i);
      logic [7:0] c;
      case (i)
         2'd0:    c = CH_A;
         2'd1:    c = CH_C;
         default: c = CH_K;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// File: rtl/atrlp_req_if.sv
`default_nettype none

interface atrlp_req_if import atrlp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/atrlp_rsp_if.sv
`default_nettype none

interface atrlp_rsp_if import atrlp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                is_frame;
   logic [BYTE_W-1:0]   payload_byte;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     sender_id;
   logic [BYTE_W-1:0]   declared_length;
   logic [PLEN_W-1:0]   payload_length;
   logic [BYTE_W-1:0]   rssi_magnitude;
   logic [BYTE_W-1:0]   snr_value;

   modport source (output valid, output is_frame, output payload_byte, output status,
                   output sender_id, output declared_length, output payload_length,
                   output rssi_magnitude, output snr_value, input ready);
   modport sink   (input valid, input is_frame, input payload_byte, input status,
                   input sender_id, input declared_length, input payload_length,
                   input rssi_magnitude, input snr_value, output ready);
endinterface

`default_nettype wire

// File: rtl/atrlp_in_stage.sv
`default_nettype none

module atrlp_in_stage import atrlp_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   atrlp_req_if.sink   req_chan,
   input  wire logic   advance,
   output in_word_type in_word
);

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              take;

   // The register empties as the parser consumes it, so a new word can enter every cycle in which the parser advances.
   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_chan.rx_byte;
      end
   end

   assign in_word.valid   = valid_ff;
   assign in_word.rx_byte = byte_ff;

endmodule

`default_nettype wire

// File: rtl/atrlp_parser.sv
`default_nettype none

module atrlp_parser import atrlp_pkg::*; #(
   parameter int LINE_MAX    = DEFAULT_LINE_MAX,
   parameter int PAYLOAD_MAX = DEFAULT_PAYLOAD_MAX
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [BYTE_W-1:0] rx_byte,
   output result_type             result
);

   localparam int LCW = $clog2(LINE_MAX + 1);
   localparam int PCW = $clog2(PAYLOAD_MAX);

   phase_type         phase_ff, phase_in;
   prefix_type        prefix_ff, prefix_in;
   logic [LCW-1:0]    line_count_ff, line_count_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [7:0]        len_ff, len_in;
   logic [PCW-1:0]    pcount_ff, pcount_in;
   logic [1:0]        ack_ff, ack_in;
   logic [7:0]        rssi_ff, rssi_in;
   logic [7:0]        snr_ff, snr_in;
   status_type        status_ff, status_in;

   always_comb begin
      logic           digit;
      logic [3:0]     dval;
      logic [PCW-1:0] limit;
      logic [8:0]     pc_wide;
      status_type     frame_st;

      phase_in      = phase_ff;
      prefix_in     = prefix_ff;
      line_count_in = line_count_ff;
      id_in         = id_ff;
      len_in        = len_ff;
      pcount_in     = pcount_ff;
      ack_in        = ack_ff;
      rssi_in       = rssi_ff;
      snr_in        = snr_ff;
      status_in     = status_ff;
      result        = '0;

      digit   = is_digit(rx_byte);
      dval    = rx_byte[3:0];
      limit   = (9'(len_ff) < 9'(PAYLOAD_MAX)) ? len_ff[PCW-1:0] : PCW'(PAYLOAD_MAX - 1);
      pc_wide = 9'(pcount_ff);

      if (phase_ff == PH_TAIL || phase_ff == PH_SNR) begin
         frame_st = status_ff;
      end else if (phase_ff == PH_PREFIX) begin
         frame_st = ST_UNKNOWN;
      end else begin
         frame_st = ST_FMTERR;
      end

      if (step) begin
         if (phase_ff == PH_HUNT) begin
            if (rx_byte == CH_PLUS) begin
               phase_in      = PH_PREFIX;
               prefix_in     = PFX_PLUS;
               line_count_in = LCW'(1);
               id_in         = '0;
               len_in        = '0;
               pcount_in     = '0;
               ack_in        = '0;
               rssi_in       = '0;
               snr_in        = '0;
               status_in     = ST_UNKNOWN;
            end
         end else if (rx_byte == CH_NL || line_count_ff >= LCW'(LINE_MAX)) begin
            // End of line, or a line that ran too long: emit the frame.
            result.valid                = 1'b1;
            result.word.is_frame        = 1'b1;
            result.word.status          = frame_st;
            result.word.sender_id       = id_ff;
            result.word.declared_length = len_ff;
            result.word.payload_length  = pc_wide[PLEN_W-1:0];
            result.word.rssi_magnitude  = rssi_ff;
            result.word.snr_value       = snr_ff;
            phase_in                    = PH_HUNT;
            prefix_in                   = PFX_NONE;
            line_count_in               = '0;
         end else begin
            line_count_in = line_count_ff + LCW'(1);
            unique case (phase_ff)
               PH_PREFIX: begin
                  // Any byte that breaks the prefix makes the line unknown.
                  phase_in  = PH_TAIL;
                  status_in = ST_UNKNOWN;
                  case (prefix_ff)
                     PFX_PLUS: begin
                        if (rx_byte == CH_O) begin
                           phase_in = PH_PREFIX; prefix_in = PFX_O;
                        end else if (rx_byte == CH_R) begin
                           phase_in = PH_PREFIX; prefix_in = PFX_R;
                        end else if (rx_byte == CH_E) begin
                           phase_in = PH_PREFIX; prefix_in = PFX_E;
                        end
                     end
                     PFX_O: begin
                        if (rx_byte == CH_K) begin
                           status_in = ST_OK;
                        end
                     end
                     PFX_R: begin
                        if (rx_byte == CH_C) begin
                           phase_in = PH_PREFIX; prefix_in = PFX_RC;
                        end
                     end
                     PFX_RC: begin
                        if (rx_byte == CH_V) begin
                           phase_in  = PH_SEEK_EQ;
                           status_in = status_ff;
                        end
                     end
                     PFX_E: begin
                        if (rx_byte == CH_R) begin
                           phase_in = PH_PREFIX; prefix_in = PFX_ER;
                        end
                     end
                     PFX_ER: begin
                        if (rx_byte == CH_R) begin
                           status_in = ST_MODERR;
                        end
                     end
                     default: ;
                  endcase
               end
               PH_SEEK_EQ: begin
                  if (rx_byte == CH_EQ) begin
                     phase_in = PH_ID;
                  end
               end
               PH_ID: begin
                  if (digit) begin
                     id_in = sat_digit16(id_ff, dval);
                  end else if (rx_byte == CH_COMMA) begin
                     phase_in = PH_LEN;
                  end else begin
                     status_in = ST_FMTERR;
                     phase_in  = PH_TAIL;
                  end
               end
               PH_LEN: begin
                  if (digit) begin
                     len_in = sat_digit8(len_ff, dval);
                  end else if (rx_byte == CH_COMMA) begin
                     phase_in  = PH_DATA;
                     pcount_in = '0;
                     ack_in    = '0;
                  end else begin
                     status_in = ST_FMTERR;
                     phase_in  = PH_TAIL;
                  end
               end
               PH_DATA: begin
                  if (rx_byte == CH_COMMA) begin
                     phase_in = PH_SIGN;
                  end else if (pcount_ff < limit) begin
                     // Track whether the payload opens with the acknowledge text.
                     if (ack_ff != 2'd3 && pc_wide == 9'(ack_ff) &&
                         rx_byte == ack_char(ack_ff)) begin
                        ack_in = ack_ff + 2'd1;
                     end
                     pcount_in                = pcount_ff + PCW'(1);
                     result.valid             = 1'b1;
                     result.word.payload_byte = rx_byte;
                  end
               end
               PH_SIGN: begin
                  phase_in = PH_RSSI;
               end
               PH_RSSI: begin
                  if (digit) begin
                     rssi_in = sat_digit8(rssi_ff, dval);
                  end else if (rx_byte == CH_COMMA) begin
                     phase_in  = PH_SNR;
                     status_in = (ack_ff == 2'd3) ? ST_ACK : ST_RCV;
                  end else begin
                     status_in = ST_FMTERR;
                     phase_in  = PH_TAIL;
                  end
               end
               PH_SNR: begin
                  if (digit) begin
                     snr_in = sat_digit8(snr_ff, dval);
                  end else begin
                     phase_in = PH_TAIL;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         prefix_ff     <= PFX_NONE;
         line_count_ff <= '0;
         id_ff         <= '0;
         len_ff        <= '0;
         pcount_ff     <= '0;
         ack_ff        <= '0;
         rssi_ff       <= '0;
         snr_ff        <= '0;
         status_ff     <= ST_UNKNOWN;
      end else begin
         phase_ff      <= phase_in;
         prefix_ff     <= prefix_in;
         line_count_ff <= line_count_in;
         id_ff         <= id_in;
         len_ff        <= len_in;
         pcount_ff     <= pcount_in;
         ack_ff        <= ack_in;
         rssi_ff       <= rssi_in;
         snr_ff        <= snr_in;
         status_ff     <= status_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/atrlp_out_stage.sv
`default_nettype none

module atrlp_out_stage import atrlp_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  step,
   input  result_type result,
   output logic       slot_free,
   atrlp_rsp_if.source rsp_chan
);

   logic         valid_ff, valid_in;
   rsp_word_type word_ff;
   logic         load;

   // The slot frees in the same cycle its word is taken.
   assign slot_free = !valid_ff || rsp_chan.ready;
   assign load      = step && result.valid;

   always_comb begin
      valid_in = valid_ff;
      if (slot_free) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= result.word;
      end
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.is_frame        = word_ff.is_frame;
   assign rsp_chan.payload_byte    = word_ff.payload_byte;
   assign rsp_chan.status          = word_ff.status;
   assign rsp_chan.sender_id       = word_ff.sender_id;
   assign rsp_chan.declared_length = word_ff.declared_length;
   assign rsp_chan.payload_length  = word_ff.payload_length;
   assign rsp_chan.rssi_magnitude  = word_ff.rssi_magnitude;
   assign rsp_chan.snr_value       = word_ff.snr_value;

endmodule

`default_nettype wire

// File: rtl/at_response_line_parser_top.sv
// Response line parser for a serial radio module. Each request word carries one received
// character; the parser hunts for a '+', classifies the line as +OK, +RCV, +ERR or unknown,
// passes the payload characters of a +RCV line, up to the declared length and at most
// PAYLOAD_MAX-1 of them, out one response word each (is_frame low), and closes every line
// at its newline with one frame word (is_frame high) holding the status, sender id,
// declared length, payload count, RSSI magnitude and SNR. A line that reaches LINE_MAX
// characters is closed by the next character, which is dropped. The block takes one
// character per clock cycle; the input stalls only while a finished response word waits
// to be taken. A response word passes through the input register and then the output register.
`default_nettype none

module at_response_line_parser_top import atrlp_pkg::*; #(
   parameter int LINE_MAX    = DEFAULT_LINE_MAX,
   parameter int PAYLOAD_MAX = DEFAULT_PAYLOAD_MAX
) (
   input wire logic    clock,
   input wire logic    reset,
   atrlp_req_if.sink   req_chan,
   atrlp_rsp_if.source rsp_chan
);

   // The incoming character is registered first. Then the parser state and the output
   // register update together, which happens whenever the output register is empty
   // or its word is being taken. Characters that produce no result still pass through that
   // step, so the parser state always advances in arrival order.
   in_word_type in_word;
   result_type  result;
   logic        slot_free;
   logic        advance;

   assign advance = in_word.valid && slot_free;

   atrlp_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .in_word  (in_word)
   );

   // All line parsing state lives here: phase, prefix match, line and payload counters,
   // the saturating decimal accumulators, and the acknowledge text match.
   atrlp_parser #(
      .LINE_MAX    (LINE_MAX),
      .PAYLOAD_MAX (PAYLOAD_MAX)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_word.rx_byte),
      .result  (result)
   );

   // The output register holds a finished response word for the receiver. While that word
   // waits, the parser cannot step, so a character already held in the input register keeps
   // the next one out until the response word is taken.
   atrlp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .result    (result),
      .slot_free (slot_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

// File: sim/at_response_line_parser_checker.sv
`timescale 1ns / 1ps

module at_response_line_parser_checker import atrlp_pkg::*; #(
   parameter int LINE_MAX    = DEFAULT_LINE_MAX,
   parameter int PAYLOAD_MAX = DEFAULT_PAYLOAD_MAX
) (
   input  logic  clock,
   input  logic  reset,
   atrlp_req_if  req_mon,
   atrlp_rsp_if  rsp_mon,
   output int    fail_count,
   output int    pending
);

   localparam logic [23:0] ACK_TEXT = {CH_A, CH_C, CH_K};

   // Parser state as the block should hold it.
   phase_type        line_phase;
   prefix_type       pfx;
   int               line_len;
   logic [ID_W-1:0]  id_acc;
   logic [7:0]       len_acc;
   int               pay_cnt;
   int               ack_cnt;
   logic [7:0]       rssi_acc;
   logic [7:0]       snr_acc;
   status_type       line_st;

   rsp_word_type     expected_words[$];

   function automatic logic decimal_char(input logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

   // Shift one decimal digit into an accumulator, clamping at maxv.
   function automatic int dec_push(input int acc, input logic [7:0] b, input int maxv);
      int v;
      v = acc * 10 + int'(b) - int'(CH_ZERO);
      return (v > maxv) ? maxv : v;
   endfunction

   function automatic string word_text(input rsp_word_type w);
      return $sformatf("frame=%0b byte=%02h status=%0d id=%0d len=%0d plen=%0d rssi=%0d snr=%0d",
                       w.is_frame, w.payload_byte, w.status, w.sender_id, w.declared_length,
                       w.payload_length, w.rssi_magnitude, w.snr_value);
   endfunction

   task automatic clear_line();
      line_phase = PH_HUNT;
      pfx        = PFX_NONE;
      line_len   = 0;
      id_acc     = '0;
      len_acc    = '0;
      pay_cnt    = 0;
      ack_cnt    = 0;
      rssi_acc   = '0;
      snr_acc    = '0;
      line_st    = ST_UNKNOWN;
   endtask

   task automatic predict_char(input logic [7:0] b);
      rsp_word_type w;
      prefix_type   nxt;
      int           lim;
      w = '0;
      if (line_phase == PH_HUNT) begin
         if (b == CH_PLUS) begin
            clear_line();
            line_phase = PH_PREFIX;
            pfx        = PFX_PLUS;
            line_len   = 1;
         end
         return;
      end
      if (b == CH_NL || line_len >= LINE_MAX) begin
         w.is_frame = 1'b1;
         if (line_phase == PH_TAIL || line_phase == PH_SNR) w.status = line_st;
         else if (line_phase == PH_PREFIX) w.status = ST_UNKNOWN;
         else w.status = ST_FMTERR;
         w.sender_id       = id_acc;
         w.declared_length = len_acc;
         w.payload_length  = pay_cnt[PLEN_W-1:0];
         w.rssi_magnitude  = rssi_acc;
         w.snr_value       = snr_acc;
         expected_words.push_back(w);
         line_phase = PH_HUNT;
         pfx        = PFX_NONE;
         line_len   = 0;
         return;
      end
      line_len++;
      case (line_phase)
         PH_PREFIX: begin
            nxt = PFX_NONE;
            case (pfx)
               PFX_PLUS: begin
                  if (b == CH_O) nxt = PFX_O;
                  else if (b == CH_R) nxt = PFX_R;
                  else if (b == CH_E) nxt = PFX_E;
               end
               PFX_O: begin
                  if (b == CH_K) begin
                     line_st = ST_OK;
                     line_phase = PH_TAIL;
                     return;
                  end
               end
               PFX_R: begin
                  if (b == CH_C) nxt = PFX_RC;
               end
               PFX_RC: begin
                  if (b == CH_V) begin
                     line_phase = PH_SEEK_EQ;
                     return;
                  end
               end
               PFX_E: begin
                  if (b == CH_R) nxt = PFX_ER;
               end
               PFX_ER: begin
                  if (b == CH_R) begin
                     line_st = ST_MODERR;
                     line_phase = PH_TAIL;
                     return;
                  end
               end
               default: ;
            endcase
            if (nxt == PFX_NONE) begin
               line_st = ST_UNKNOWN;
               line_phase = PH_TAIL;
            end else begin
               pfx = nxt;
            end
         end
         PH_SEEK_EQ: begin
            if (b == CH_EQ) line_phase = PH_ID;
         end
         PH_ID: begin
            if (decimal_char(b)) id_acc = ID_W'(dec_push(int'(id_acc), b, 65535));
            else if (b == CH_COMMA) line_phase = PH_LEN;
            else begin
               line_st = ST_FMTERR;
               line_phase = PH_TAIL;
            end
         end
         PH_LEN: begin
            if (decimal_char(b)) len_acc = 8'(dec_push(int'(len_acc), b, 255));
            else if (b == CH_COMMA) begin
               line_phase = PH_DATA;
               pay_cnt = 0;
               ack_cnt = 0;
            end else begin
               line_st = ST_FMTERR;
               line_phase = PH_TAIL;
            end
         end
         PH_DATA: begin
            lim = (int'(len_acc) < PAYLOAD_MAX) ? int'(len_acc) : PAYLOAD_MAX - 1;
            if (b == CH_COMMA) line_phase = PH_SIGN;
            else if (pay_cnt < lim) begin
               if (ack_cnt < 3 && ack_cnt == pay_cnt && b == ACK_TEXT[23 - 8 * ack_cnt -: 8])
                  ack_cnt++;
               pay_cnt++;
               w.payload_byte = b;
               expected_words.push_back(w);
            end
         end
         PH_SIGN: line_phase = PH_RSSI;
         PH_RSSI: begin
            if (decimal_char(b)) rssi_acc = 8'(dec_push(int'(rssi_acc), b, 255));
            else if (b == CH_COMMA) begin
               line_phase = PH_SNR;
               line_st = (ack_cnt == 3) ? ST_ACK : ST_RCV;
            end else begin
               line_st = ST_FMTERR;
               line_phase = PH_TAIL;
            end
         end
         PH_SNR: begin
            if (decimal_char(b)) snr_acc = 8'(dec_push(int'(snr_acc), b, 255));
            else line_phase = PH_TAIL;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         clear_line();
         expected_words.delete();
         fail_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready) predict_char(req_mon.rx_byte);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.is_frame        = rsp_mon.is_frame;
            got.payload_byte    = rsp_mon.payload_byte;
            got.status          = status_type'(rsp_mon.status);
            got.sender_id       = rsp_mon.sender_id;
            got.declared_length = rsp_mon.declared_length;
            got.payload_length  = rsp_mon.payload_length;
            got.rssi_magnitude  = rsp_mon.rssi_magnitude;
            got.snr_value       = rsp_mon.snr_value;
            if (expected_words.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected response word: %s", $realtime, word_text(got));
               fail_count <= fail_count + 1;
            end else begin
               want = expected_words.pop_front();
               if (got.is_frame !== want.is_frame || got.payload_byte !== want.payload_byte ||
                   got.status !== want.status || got.sender_id !== want.sender_id ||
                   got.declared_length !== want.declared_length ||
                   got.payload_length !== want.payload_length ||
                   got.rssi_magnitude !== want.rssi_magnitude ||
                   got.snr_value !== want.snr_value) begin
                  if (fail_count < 10) begin
                     $display("%0t: response word mismatch", $realtime);
                     $display("   expected %s", word_text(want));
                     $display("   actual   %s", word_text(got));
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= expected_words.size();
   end

endmodule

// File: sim/at_response_line_parser_top_test.sv
`timescale 1ns / 1ps

module at_response_line_parser_top_test;
   import atrlp_pkg::*;

   localparam int LINE_MAX    = DEFAULT_LINE_MAX;
   localparam int PAYLOAD_MAX = DEFAULT_PAYLOAD_MAX;

   logic clock;
   logic reset;

   atrlp_req_if req_chan ();
   atrlp_rsp_if rsp_chan ();

   int fail_count;
   int pending;

   // Percentages of cycles in which the sender and the receiver hold off.
   int sender_idle_pct;
   int receiver_idle_pct;

   // Characters of the line being assembled, and the number of characters sent.
   logic [7:0] line_bytes[$];
   int         items_sent;

   at_response_line_parser_top #(
      .LINE_MAX    (LINE_MAX),
      .PAYLOAD_MAX (PAYLOAD_MAX)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // The checker sits beside the block, watches both channels and counts failures.
   at_response_line_parser_checker #(
      .LINE_MAX    (LINE_MAX),
      .PAYLOAD_MAX (PAYLOAD_MAX)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // The receiver decides afresh at every rising edge whether it takes a word.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Hand one character to the block. Idle cycles come first, with valid low, and then
   // valid is held until the block takes the word. The ready seen after the edge is the
   // value the block had at that edge, so the loop exits exactly on acceptance.
   task automatic send_char(input logic [7:0] b);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
   endtask

   task automatic add_digits(input int count);
      for (int i = 0; i < count; i++) line_bytes.push_back(8'(CH_ZERO + $urandom_range(9)));
   endtask

   // Any character except the two that end a data field.
   function automatic logic [7:0] data_char();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == CH_COMMA || b == CH_NL) b = 8'h61;
      return b;
   endfunction

   task automatic send_line();
      foreach (line_bytes[i]) send_char(line_bytes[i]);
      line_bytes.delete();
   endtask

   task automatic send_text(input string s);
      add_text(s);
      send_line();
   endtask

   // A received-data line with random content. Most are well formed; a few have one
   // character overwritten with an arbitrary value so that the error paths are reached.
   task automatic build_rcv_line();
      int plen;
      int data_n;
      int pick;
      bit ack_lead;
      add_text("+RCV=");
      add_digits($urandom_range(0, 6));
      line_bytes.push_back(CH_COMMA);
      pick = $urandom_range(99);
      if (pick < 70) plen = $urandom_range(0, 8);
      else if (pick < 90) plen = $urandom_range(9, 40);
      else plen = -1;
      if (plen < 0) begin
         add_digits($urandom_range(1, 4));
         data_n = $urandom_range(0, 70);
      end else begin
         add_text($sformatf("%0d", plen));
         data_n = ($urandom_range(4) == 0) ? $urandom_range(0, plen + 3) : plen;
      end
      line_bytes.push_back(CH_COMMA);
      ack_lead = ($urandom_range(2) == 0);
      for (int i = 0; i < data_n; i++) begin
         if (ack_lead && i == 0) line_bytes.push_back(CH_A);
         else if (ack_lead && i == 1) line_bytes.push_back(CH_C);
         else if (ack_lead && i == 2) line_bytes.push_back(CH_K);
         else line_bytes.push_back(data_char());
      end
      line_bytes.push_back(CH_COMMA);
      // The sign character is skipped by the parser, whatever it is, unless it is a newline.
      line_bytes.push_back(($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'h2D);
      add_digits($urandom_range(0, 4));
      line_bytes.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : CH_COMMA);
      add_digits($urandom_range(0, 4));
      if ($urandom_range(9) == 0)
         for (int i = 0; i < $urandom_range(1, 6); i++) line_bytes.push_back(data_char());
      line_bytes.push_back(CH_NL);
      if ($urandom_range(99) < 15)
         line_bytes[$urandom_range(1, line_bytes.size() - 1)] = 8'($urandom_range(255));
   endtask

   // A line of random text after the plus sign, usually with an unknown prefix.
   task automatic build_other_line();
      line_bytes.push_back(CH_PLUS);
      for (int i = 0; i < $urandom_range(0, 8); i++) line_bytes.push_back(data_char());
      line_bytes.push_back(CH_NL);
   endtask

   initial begin
      string directed[$];
      int    target;
      int    pick;
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= '0;
      items_sent        = 0;
      sender_idle_pct   = 22;
      receiver_idle_pct = 59;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Characters outside any line are dropped while the parser hunts for a plus sign.
      send_char(8'h00);
      send_char(8'hFF);
      send_char(CH_NL);

      // Each prefix, short and broken prefixes, and a plus sign inside a line.
      directed = '{"+OK\n", "+ERR\n", "+ERR busy\n", "+E\n", "+\n", "+OX\n", "+RX\n",
                   "+RC\n", "+XYZ\n", "+OK+RCV\n",
                   // Received lines: acknowledge payload, saturation, and error cases.
                   "+RCV=12,3,ACK,-40,9\n", "+RCV=65535,5,hello,-255,255\n",
                   "+RCV=99999,999,ab,-999,999\n", "+RCV,1,2\n", "+RCV=1a,2,ab,-1,1\n",
                   "+RCV=1,2b,ab,-1,1\n", "+RCV=1,2,ab,-5x\n", "+RCV=1,2,ab,-5\n",
                   "+RCV=1,4,ab\n", "+RCV=1,2,ab,\n", "+RCV=7,2,ab,+7,3 tail,9\n",
                   "+RCV=0,0,,-0,0\n", "+RCV=3,2,AC,-1,1\n", "+RCV=3,4,ACKX,-1,1\n",
                   "+RCV=3,3,ACX,-1,1\n", "+RCV=1,2,abcdef,-1,1\n"};
      foreach (directed[i]) send_text(directed[i]);

      // Extreme data values inside a payload.
      add_text("+RCV=1,2,");
      line_bytes.push_back(8'h00);
      line_bytes.push_back(8'hFF);
      add_text(",-1,1\n");
      send_line();

      // A line that runs past its maximum length, once as text and once inside the data.
      line_bytes.push_back(CH_PLUS);
      for (int i = 0; i < LINE_MAX + 6; i++) line_bytes.push_back(8'h78);
      line_bytes.push_back(CH_NL);
      send_line();
      add_text("+RCV=1,200,");
      for (int i = 0; i < LINE_MAX; i++) line_bytes.push_back(data_char());
      add_text(",-1,1\n");
      send_line();

      // Random lines, in three spells: slow receiver, slow sender, then no idling at all.
      target = items_sent;
      for (int spell = 0; spell < 3; spell++) begin
         case (spell)
            0: begin
               sender_idle_pct   = 22;
               receiver_idle_pct = 59;
            end
            1: begin
               sender_idle_pct   = 59;
               receiver_idle_pct = 22;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         target += 60;
         while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 62) begin
               build_rcv_line();
               send_line();
            end else if (pick < 70) begin
               send_text(($urandom_range(1) == 0) ? "+OK\n" : "+OK ready\n");
            end else if (pick < 78) begin
               send_text("+ERR\n");
            end else if (pick < 90) begin
               build_other_line();
               send_line();
            end else begin
               // Noise between lines; it may open a line of its own by chance.
               for (int i = 0; i < $urandom_range(1, 8); i++) send_char(8'($urandom_range(255)));
            end
         end
      end
      req_chan.valid <= 1'b0;

      // Let the last word settle into the checker, then wait until nothing is owed.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("** at_response_line_parser_top: PASSED **");
      end else begin
         $display("** at_response_line_parser_top: FAILED **");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("** at_response_line_parser_top: FAILED **");
      $finish;
   end

endmodule
